// ----- hdl/strm_pkg.sv -----
// Shared types and constants for the segment tree range-maximum block.
`timescale 1ns / 1ps

package strm_pkg;

  localparam int DATA_W = 32;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic fold;
  } acc_ctl_t;

endpackage

// ----- hdl/segment_tree_range_max.sv -----
// Top level of the segment tree range-maximum block: node memory and sequencer.
`timescale 1ns / 1ps

// Segment tree over LEAVES unsigned 32-bit values, rounded up to a power of two
// (TSIZE) and kept as a heap of 2*TSIZE nodes in one single-port-read node memory.
// After reset the block sweeps the memory to zero, one node a cycle, over all
// 2*TSIZE nodes, and holds in_stall high meanwhile. An update writes the leaf,
// then does one read of the sibling and one write of the parent per level
// through the shared max unit. A query climbs the tree one level per pass,
// one node read a cycle. One item is in work at a time; the result
// register lets the next item start while a query result waits on out_stall.
module segment_tree_range_max import strm_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [9:0]        leaf_index,
  input  logic [DATA_W-1:0] leaf_value,
  input  logic [10:0]       range_lo,
  input  logic [10:0]       range_hi,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] range_max
);

  localparam int TSIZE = 1 << $clog2(LEAVES);
  localparam int NODES = 2 * TSIZE;
  localparam int AW    = $clog2(NODES);
  localparam int IW    = AW + 1;
  localparam int CW    = (IW > 11) ? IW : 11;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_U_LEAF = 8'b0000_0100,
    ST_U_RD   = 8'b0000_1000,
    ST_U_UP   = 8'b0001_0000,
    ST_Q_L    = 8'b0010_0000,
    ST_Q_R    = 8'b0100_0000,
    ST_Q_DONE = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     clr_cnt;
  logic [AW-1:0]     node;
  logic [IW-1:0]     l, r;
  logic              pend, pend_next;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] mem [NODES];

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;

  acc_ctl_t          ctl;
  logic [DATA_W-1:0] acc, max_out;

  logic              in_take;
  logic              leaf_ok;
  logic [CW-1:0]     lo_w, hi_w, lo_c, hi_c;
  logic [IW-1:0]     r_dec;
  logic [AW-1:0]     parent;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign leaf_ok  = (32'(leaf_index) < LEAVES);
  assign lo_w     = CW'(range_lo);
  assign hi_w     = CW'(range_hi);
  assign lo_c     = (lo_w > CW'(TSIZE)) ? CW'(TSIZE) : lo_w;
  assign hi_c     = (hi_w > CW'(TSIZE)) ? CW'(TSIZE) : hi_w;
  assign r_dec    = r[0] ? (r - IW'(1)) : r;
  assign parent   = node >> 1;

  strm_max_acc u_max (
    .clk      (clk),
    .ctl      (ctl),
    .load_val (leaf_value),
    .fold_val (rd_data),
    .acc      (acc),
    .max_out  (max_out)
  );

  always_comb begin
    ctl.clear = in_take && (op == OP_QUERY);
    ctl.load  = in_take && (op == OP_UPDATE);
    ctl.fold  = pend || (state == ST_U_UP);
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = acc;
    raddr = '0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      ST_U_LEAF: begin
        we = 1'b1;
      end
      ST_U_RD: begin
        raddr = node ^ AW'(1);
      end
      ST_U_UP: begin
        we    = 1'b1;
        waddr = parent;
        wdata = max_out;
      end
      ST_Q_L: begin
        raddr = l[AW-1:0];
      end
      ST_Q_R: begin
        raddr = r_dec[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    pend_next  = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          if (op == OP_QUERY) begin
            state_next = ST_Q_L;
          end else if (leaf_ok) begin
            state_next = ST_U_LEAF;
          end
        end
      end
      ST_U_LEAF: state_next = ST_U_RD;
      ST_U_RD:   state_next = ST_U_UP;
      ST_U_UP: begin
        state_next = (parent == AW'(1)) ? ST_IDLE : ST_U_RD;
      end
      ST_Q_L: begin
        if (l < r) begin
          pend_next  = l[0];
          state_next = ST_Q_R;
        end else begin
          state_next = ST_Q_DONE;
        end
      end
      ST_Q_R: begin
        pend_next  = r[0];
        state_next = ST_Q_L;
      end
      ST_Q_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_Q_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_take) begin
      node <= AW'(TSIZE) + AW'(leaf_index);
      l    <= IW'(lo_c) + IW'(TSIZE);
      r    <= IW'(hi_c) + IW'(TSIZE);
    end else if (state == ST_U_UP) begin
      node <= parent;
    end else if (state == ST_Q_L) begin
      if (l < r && l[0]) begin
        l <= l + IW'(1);
      end
    end else if (state == ST_Q_R) begin
      l <= l >> 1;
      r <= r_dec >> 1;
    end
    if (state == ST_Q_DONE && (!out_valid || !out_stall)) begin
      range_max <= acc;
    end
  end

  a_done_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_Q_DONE |-> !pend)
    else $error("query finished with a node read still pending");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    in_take && op == OP_QUERY |=> state == ST_Q_L)
    else $error("accepted query did not start its walk");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_stall && state == ST_CLEAR)
    else $error("transaction possible before node memory sweep");

  a_update_climbs: assert property (@(posedge clk) disable iff (rst)
    state == ST_U_UP |-> node != AW'(1))
    else $error("update climbed past the root");

endmodule

// ----- hdl/strm_max_acc.sv -----
// Shared max compare unit with its running accumulator.
`timescale 1ns / 1ps

module strm_max_acc import strm_pkg::*; (
  input  logic              clk,
  input  acc_ctl_t          ctl,
  input  logic [DATA_W-1:0] load_val,
  input  logic [DATA_W-1:0] fold_val,
  output logic [DATA_W-1:0] acc,
  output logic [DATA_W-1:0] max_out
);

  logic [DATA_W-1:0] acc_q;

  assign max_out = (fold_val > acc_q) ? fold_val : acc_q;
  assign acc     = acc_q;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_q <= '0;
    end else if (ctl.load) begin
      acc_q <= load_val;
    end else if (ctl.fold) begin
      acc_q <= max_out;
    end
  end

endmodule
